/* design/bvhsah_pkg.sv */
`default_nettype none
package bvhsah_pkg;

  // Bucket count and node capacity; the result field widths below follow them.
  localparam int BUCKETS        = 12;
  localparam int MAX_PRIMITIVES = 65536;

  // Operation codes of an input beat.
  localparam logic OP_BIN      = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Result kinds.
  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_SIDE     = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_SPLIT_AXIS     = 2'd0;
  localparam logic [1:0] REG_CENTROID_LOW   = 2'd1;
  localparam logic [1:0] REG_INV_EXTENT     = 2'd2;
  localparam logic [1:0] REG_INV_NODE_AREA  = 2'd3;

  // Axis codes; the spare code selects z.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic [47:0] COST_CAP       = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] TRAVERSAL_COST = 48'h0000_0000_2000;  // 0.125 in Q16.16
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic               last;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic        split_found;
    logic [3:0]  best_bucket;
    logic [47:0] best_cost;
    logic [16:0] count_a;
    logic [16:0] count_b;
    logic        goes_left;
  } result_t;

endpackage
`default_nettype wire

/* design/bvh_sah_binned_split.sv */
`default_nettype none
// Binned SAH split finder for one BVH node. Raise start with a bin or classify
// beat on item while busy is low; the beat is taken at that edge. Each bin or
// classify beat keeps busy high through S_BKT (one shared 32x32 multiply for
// the centroid bucket) and S_BIN (the bucket update), so a new beat is taken
// only once the last is through. A bin beat flagged last then runs the plane
// evaluation on the same shared multiplier: for each of 2*(BUCKETS-1) sides it
// loads a bucket, multiplies, and stores or scores the side, then reports. A
// decision or a side result is shown on result for exactly one cycle with done
// high; the receiver cannot stall it, so it must take every beat flagged by
// done. Configuration writes are registered and are meant for idle periods only.
module bvh_sah_binned_split (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire bvhsah_pkg::item_t  item,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    done,
  output bvhsah_pkg::result_t     result
);

  localparam int BUCKETS        = bvhsah_pkg::BUCKETS;
  localparam int MAX_PRIMITIVES = bvhsah_pkg::MAX_PRIMITIVES;
  localparam int BW = $clog2(BUCKETS);
  localparam int CW = $clog2(MAX_PRIMITIVES + 1);
  localparam logic [BW-1:0] LAST_B = BW'(BUCKETS - 1);
  localparam logic [BW-1:0] LAST_S = BW'(BUCKETS - 2);

  typedef enum logic [2:0] {
    S_IDLE, S_BKT, S_BIN, S_LOAD, S_MULT, S_SIDE_DONE, S_REPORT
  } state_t;

  state_t state;

  // configuration
  logic [1:0]         split_axis;
  logic signed [31:0] centroid_low;
  logic [31:0]        inv_extent;
  logic [31:0]        inv_area;

  // bucket storage: union box, count, valid per bucket
  logic signed [31:0] row_lo  [BUCKETS][3];
  logic signed [31:0] row_hi  [BUCKETS][3];
  logic [CW-1:0]      row_cnt [BUCKETS];
  logic [BUCKETS-1:0] row_valid;
  logic [47:0]        wa_mem  [BUCKETS-1];

  logic [BW-1:0] chosen;
  logic [CW-1:0] total;
  bvhsah_pkg::item_t item_q;

  // evaluation datapath
  logic [BW-1:0]      s_idx;
  logic               phase_b;
  logic [3:0]         ms;
  logic [63:0]        pr;
  logic [49:0]        area_s;
  logic [82:0]        big;
  logic [65:0]        w;
  logic signed [31:0] u_lo [3];
  logic signed [31:0] u_hi [3];
  logic [CW-1:0]      side_cnt;
  logic [47:0]        best_cost;
  logic [BW-1:0]      best_s;
  logic [CW-1:0]      best_a;
  logic [CW-1:0]      best_b;

  // shared multiplier operands
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // centroid offset on the split axis
  logic signed [31:0] c_min, c_max;
  logic signed [32:0] c_sum;
  logic signed [33:0] c_off;
  logic [31:0]        d_pos;

  always_comb begin
    case (split_axis)
      bvhsah_pkg::AXIS_X: begin
        c_min = item_q.box_min_x;
        c_max = item_q.box_max_x;
      end
      bvhsah_pkg::AXIS_Y: begin
        c_min = item_q.box_min_y;
        c_max = item_q.box_max_y;
      end
      default: begin
        c_min = item_q.box_min_z;
        c_max = item_q.box_max_z;
      end
    endcase
    c_sum = 33'(c_min) + 33'(c_max);
    c_off = 34'(c_sum >>> 1) - 34'(centroid_low);
    d_pos = (c_off > 34'sd0) ? c_off[31:0] : 32'd0;
  end

  // bucket index from the registered centroid product
  logic [39:0]   bsum;
  logic [BW-1:0] bkt;
  always_comb begin
    bsum = {8'd0, pr[63:32]} * 40'(BUCKETS)
         + (({8'd0, pr[31:0]} * 40'(BUCKETS)) >> 32);
    bkt  = (bsum >= 40'(BUCKETS)) ? LAST_B : bsum[BW-1:0];
  end

  // input box corners as arrays
  logic signed [31:0] in_lo [3];
  logic signed [31:0] in_hi [3];
  assign in_lo[0] = item_q.box_min_x;
  assign in_lo[1] = item_q.box_min_y;
  assign in_lo[2] = item_q.box_min_z;
  assign in_hi[0] = item_q.box_max_x;
  assign in_hi[1] = item_q.box_max_y;
  assign in_hi[2] = item_q.box_max_z;

  // side weight arithmetic
  logic [31:0]   ext [3];
  logic signed [32:0] ext_d [3];
  logic [50:0]   area;
  logic [47:0]   prob;
  logic [47:0]   wsat;
  logic [BW-1:0] load_idx;
  logic [49:0]   cost_sum;
  logic [47:0]   cost;
  logic [CW-1:0] ca_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ext_d[k] = 33'(u_hi[k]) - 33'(u_lo[k]);
      ext[k]   = (u_hi[k] > u_lo[k]) ? ext_d[k][31:0] : 32'd0;
    end
    area     = {area_s, 1'b0};
    prob     = (big[82:64] != 19'd0) ? bvhsah_pkg::COST_CAP : big[63:16];
    wsat     = (side_cnt == '0) ? 48'd0 :
               ((w[65:48] != 18'd0) ? bvhsah_pkg::COST_CAP : w[47:0]);
    load_idx = phase_b ? BW'(s_idx + 1'b1) : s_idx;
    cost_sum = 50'(bvhsah_pkg::TRAVERSAL_COST) + 50'(wa_mem[s_idx]) + 50'(wsat);
    cost     = (cost_sum[49:48] != 2'd0) ? bvhsah_pkg::COST_CAP : cost_sum[47:0];
    ca_b     = total - side_cnt;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    if (state == S_BKT) begin
      mul_a = d_pos;
      mul_b = inv_extent;
    end else if (state == S_MULT) begin
      case (ms[3:1])
        3'd0: begin mul_a = ext[0]; mul_b = ext[1]; end
        3'd1: begin mul_a = ext[1]; mul_b = ext[2]; end
        3'd2: begin mul_a = ext[2]; mul_b = ext[0]; end
        3'd3: begin mul_a = area[31:0]; mul_b = inv_area; end
        3'd4: begin mul_a = {13'd0, area[50:32]}; mul_b = inv_area; end
        3'd5: begin mul_a = prob[31:0]; mul_b = 32'(side_cnt); end
        3'd6: begin mul_a = {16'd0, prob[47:32]}; mul_b = 32'(side_cnt); end
        default: begin mul_a = 32'd0; mul_b = 32'd0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pr <= 64'(mul_a) * 64'(mul_b);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      row_valid    <= '0;
      total        <= '0;
      chosen       <= '0;
      split_axis   <= 2'd0;
      centroid_low <= 32'sd0;
      inv_extent   <= 32'd0;
      inv_area     <= 32'd0;
    end else begin
      done <= 1'b0;

      // config writes land at once
      if (cfg_write) begin
        case (cfg_index)
          bvhsah_pkg::REG_SPLIT_AXIS:    split_axis   <= cfg_data[1:0];
          bvhsah_pkg::REG_CENTROID_LOW:  centroid_low <= cfg_data;
          bvhsah_pkg::REG_INV_EXTENT:    inv_extent   <= cfg_data;
          bvhsah_pkg::REG_INV_NODE_AREA: inv_area     <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            state  <= S_BKT;
          end
        end

        // multiplier forms centroid offset times inverse extent
        S_BKT: state <= S_BIN;

        S_BIN: begin
          if (item_q.operation == bvhsah_pkg::OP_CLASSIFY) begin
            done   <= 1'b1;
            result <= '{kind: bvhsah_pkg::KIND_SIDE, split_found: 1'b0,
                        best_bucket: 4'd0, best_cost: 48'd0, count_a: 17'd0,
                        count_b: 17'd0, goes_left: (bkt <= chosen)};
            state  <= S_IDLE;
          end else begin
            // drop boxes once the node is full
            if (total < CW'(MAX_PRIMITIVES)) begin
              for (int k = 0; k < 3; k++) begin
                if (!row_valid[bkt] || in_lo[k] < row_lo[bkt][k])
                  row_lo[bkt][k] <= in_lo[k];
                if (!row_valid[bkt] || in_hi[k] > row_hi[bkt][k])
                  row_hi[bkt][k] <= in_hi[k];
              end
              row_cnt[bkt]   <= row_valid[bkt] ? CW'(row_cnt[bkt] + 1'b1) : CW'(1);
              row_valid[bkt] <= 1'b1;
              total          <= CW'(total + 1'b1);
            end
            if (item_q.last) begin
              s_idx    <= '0;
              phase_b  <= 1'b0;
              side_cnt <= '0;
              for (int k = 0; k < 3; k++) begin
                u_lo[k] <= bvhsah_pkg::COORD_MAX;
                u_hi[k] <= bvhsah_pkg::COORD_MIN;
              end
              state <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        // grow the running union by one bucket
        S_LOAD: begin
          if (row_valid[load_idx]) begin
            for (int k = 0; k < 3; k++) begin
              if (row_lo[load_idx][k] < u_lo[k]) u_lo[k] <= row_lo[load_idx][k];
              if (row_hi[load_idx][k] > u_hi[k]) u_hi[k] <= row_hi[load_idx][k];
            end
            side_cnt <= CW'(side_cnt + row_cnt[load_idx]);
          end
          ms    <= 4'd0;
          state <= S_MULT;
        end

        // issue on even steps, consume the product on odd steps
        S_MULT: begin
          if (ms[0]) begin
            case (ms[3:1])
              3'd0: area_s <= 50'(pr[63:16]);
              3'd1: area_s <= area_s + 50'(pr[63:16]);
              3'd2: area_s <= area_s + 50'(pr[63:16]);
              3'd3: big    <= 83'(pr);
              3'd4: big    <= big + (83'(pr) << 32);
              3'd5: w      <= 66'(pr);
              3'd6: w      <= w + (66'(pr) << 32);
              default: ;
            endcase
          end
          ms <= 4'(ms + 1'b1);
          if (ms == 4'd13) state <= S_SIDE_DONE;
        end

        S_SIDE_DONE: begin
          if (!phase_b) begin
            wa_mem[s_idx] <= wsat;
            if (s_idx == LAST_S) begin
              // start the right-hand sweep from the top bucket down
              phase_b  <= 1'b1;
              side_cnt <= '0;
              for (int k = 0; k < 3; k++) begin
                u_lo[k] <= bvhsah_pkg::COORD_MAX;
                u_hi[k] <= bvhsah_pkg::COORD_MIN;
              end
            end else begin
              s_idx <= BW'(s_idx + 1'b1);
            end
            state <= S_LOAD;
          end else begin
            // descending sweep: ties go to the lower plane
            if (s_idx == LAST_S || cost <= best_cost) begin
              best_cost <= cost;
              best_s    <= s_idx;
              best_a    <= ca_b;
              best_b    <= side_cnt;
            end
            if (s_idx == '0) begin
              state <= S_REPORT;
            end else begin
              s_idx <= BW'(s_idx - 1'b1);
              state <= S_LOAD;
            end
          end
        end

        S_REPORT: begin
          done      <= 1'b1;
          result    <= '{kind: bvhsah_pkg::KIND_DECISION,
                         split_found: (best_cost < (48'(total) << 16)),
                         best_bucket: 4'(best_s), best_cost: best_cost,
                         count_a: 17'(best_a), count_b: 17'(best_b),
                         goes_left: 1'b0};
          chosen    <= best_s;
          row_valid <= '0;
          total     <= '0;
          state     <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/sv/bvh_sah_binned_split_tb.sv */
`default_nettype none
// Testbench for the binned SAH split finder. A directed stimulus table goes
// first, then random binning passes under several register settings and idle
// patterns. Every result beat is checked field by field against a hand-checked
// table value or a local model of the buckets and the plane evaluation.
module bvh_sah_binned_split_tb;

  localparam int NB = bvhsah_pkg::BUCKETS;
  localparam int PRIM_LIMIT = bvhsah_pkg::MAX_PRIMITIVES;
  localparam logic [127:0] LO32 = 128'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bvhsah_pkg::item_t item = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  bvhsah_pkg::result_t result;

  bvh_sah_binned_split dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Model copy of the registers.
  logic [1:0] m_axis;
  logic signed [31:0] m_centroid_low;
  logic [31:0] m_inv_extent;
  logic [31:0] m_inv_area;

  // Model copy of the bucket state.
  longint bin_lo[NB*3];
  longint bin_hi[NB*3];
  int unsigned bin_cnt[NB];
  int unsigned chosen_split;
  int unsigned prims_binned;

  bvhsah_pkg::result_t pending_results[$];
  int err_count = 0;

  // Generator state for well-formed boxes.
  int gen_low;
  int gen_extent;

  typedef struct {
    bit                  wr;
    logic [1:0]          idx;
    logic [31:0]         val;
    bvhsah_pkg::item_t   it;
    bit                  typed;
    bvhsah_pkg::result_t want;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic void clear_buckets();
    for (int i = 0; i < NB*3; i++) begin
      bin_lo[i] = 64'sd2147483647;
      bin_hi[i] = -64'sd2147483648;
    end
    for (int i = 0; i < NB; i++) bin_cnt[i] = 0;
    prims_binned = 0;
  endfunction

  // Saturating Q16.16 product.
  function automatic logic [47:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> 16;
    return (p > {80'd0, bvhsah_pkg::COST_CAP}) ? bvhsah_pkg::COST_CAP : p[47:0];
  endfunction

  function automatic int unsigned bucket_index(bvhsah_pkg::item_t it);
    logic [1:0] ax;
    logic signed [31:0] mn, mx;
    logic signed [32:0] sum, cen;
    longint d;
    logic [127:0] p, b;
    ax = (m_axis > 2'd2) ? 2'd2 : m_axis;
    case (ax)
      bvhsah_pkg::AXIS_X: begin mn = it.box_min_x; mx = it.box_max_x; end
      bvhsah_pkg::AXIS_Y: begin mn = it.box_min_y; mx = it.box_max_y; end
      default: begin mn = it.box_min_z; mx = it.box_max_z; end
    endcase
    sum = $signed({mn[31], mn}) + $signed({mx[31], mx});
    cen = sum >>> 1;
    d = longint'(cen) - longint'(m_centroid_low);
    if (d <= 0) return 0;
    p = 128'(d) * {96'd0, m_inv_extent};
    b = (p >> 32) * NB + (((p & LO32) * NB) >> 32);
    return (b >= NB) ? NB - 1 : int'(b);
  endfunction

  // Surface area of the union of buckets first..lastb.
  function automatic logic [63:0] union_area(int first, int lastb);
    longint lo[3], hi[3];
    logic [127:0] e[3];
    logic [127:0] s;
    for (int k = 0; k < 3; k++) begin
      lo[k] = 64'sd2147483647;
      hi[k] = -64'sd2147483648;
    end
    for (int i = first; i <= lastb; i++)
      for (int k = 0; k < 3; k++) begin
        if (bin_lo[i*3+k] < lo[k]) lo[k] = bin_lo[i*3+k];
        if (bin_hi[i*3+k] > hi[k]) hi[k] = bin_hi[i*3+k];
      end
    for (int k = 0; k < 3; k++) e[k] = (hi[k] > lo[k]) ? 128'(hi[k] - lo[k]) : 128'd0;
    s = ((e[0]*e[1]) >> 16) + ((e[1]*e[2]) >> 16) + ((e[2]*e[0]) >> 16);
    return 64'(2 * s);
  endfunction

  // Score all planes, take the first minimum, then reset the buckets.
  function automatic bvhsah_pkg::result_t split_decision();
    bvhsah_pkg::result_t r;
    logic [63:0] ca, cb, cost, wa, wb, top_cost;
    int top;
    logic [63:0] top_a, top_b;
    top_cost = 0; top = 0; top_a = 0; top_b = 0;
    for (int s = 0; s < NB - 1; s++) begin
      ca = 0; cb = 0; wa = 0; wb = 0;
      for (int i = 0; i <= s; i++) ca += bin_cnt[i];
      for (int i = s + 1; i < NB; i++) cb += bin_cnt[i];
      if (ca != 0) wa = qmul(qmul(union_area(0, s), m_inv_area), ca << 16);
      if (cb != 0) wb = qmul(qmul(union_area(s + 1, NB - 1), m_inv_area), cb << 16);
      cost = bvhsah_pkg::TRAVERSAL_COST + wa + wb;
      if (cost > bvhsah_pkg::COST_CAP) cost = bvhsah_pkg::COST_CAP;
      if (s == 0 || cost < top_cost) begin
        top_cost = cost; top = s; top_a = ca; top_b = cb;
      end
    end
    r = '0;
    r.kind = bvhsah_pkg::KIND_DECISION;
    r.split_found = top_cost < (64'(prims_binned) << 16);
    r.best_bucket = top[3:0];
    r.best_cost = top_cost[47:0];
    r.count_a = top_a[16:0];
    r.count_b = top_b[16:0];
    chosen_split = top;
    clear_buckets();
    return r;
  endfunction

  // Advance the model by one accepted beat; queue any result it causes.
  task automatic predict_beat(bvhsah_pkg::item_t it, bit typed, bvhsah_pkg::result_t want);
    bvhsah_pkg::result_t r;
    int unsigned b;
    bit produced;
    produced = 1'b0;
    r = '0;
    if (it.operation == bvhsah_pkg::OP_CLASSIFY) begin
      r.kind = bvhsah_pkg::KIND_SIDE;
      r.goes_left = bucket_index(it) <= chosen_split;
      produced = 1'b1;
    end else begin
      if (prims_binned < PRIM_LIMIT) begin
        b = bucket_index(it);
        if (it.box_min_x < bin_lo[b*3])   bin_lo[b*3]   = it.box_min_x;
        if (it.box_min_y < bin_lo[b*3+1]) bin_lo[b*3+1] = it.box_min_y;
        if (it.box_min_z < bin_lo[b*3+2]) bin_lo[b*3+2] = it.box_min_z;
        if (it.box_max_x > bin_hi[b*3])   bin_hi[b*3]   = it.box_max_x;
        if (it.box_max_y > bin_hi[b*3+1]) bin_hi[b*3+1] = it.box_max_y;
        if (it.box_max_z > bin_hi[b*3+2]) bin_hi[b*3+2] = it.box_max_z;
        bin_cnt[b]++;
        prims_binned++;
      end
      if (it.last) begin
        r = split_decision();
        produced = 1'b1;
      end
    end
    // Typed rows: the table value stands in for the model's answer.
    if (produced) pending_results.insert(pending_results.size(), typed ? want : r);
  endtask

  // Drive one beat at the falling edge and hold it until it is taken.
  task automatic send_beat(bvhsah_pkg::item_t it, int idle_pct, bit typed = 1'b0,
                           bvhsah_pkg::result_t want = '0);
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_beat(it, typed, want);
  endtask

  // Drop start and let the block go idle: all results in, plus the
  // evaluation latency in case a beat still runs without a result.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bvhsah_pkg::REG_SPLIT_AXIS:   m_axis = val[1:0];
      bvhsah_pkg::REG_CENTROID_LOW: m_centroid_low = val;
      bvhsah_pkg::REG_INV_EXTENT:   m_inv_extent = val;
      default:                      m_inv_area = val;
    endcase
  endtask

  function automatic bvhsah_pkg::item_t make_item(logic op, int x0, int y0, int z0,
                                                  int x1, int y1, int z1, logic lst);
    bvhsah_pkg::item_t it;
    it.operation = op;
    it.box_min_x = x0; it.box_min_y = y0; it.box_min_z = z0;
    it.box_max_x = x1; it.box_max_y = y1; it.box_max_z = z1;
    it.last = lst;
    return it;
  endfunction

  // Box whose centroid lands inside the configured range, give or take.
  function automatic bvhsah_pkg::item_t shaped_box(logic op, logic lst);
    int c[3], h[3];
    for (int k = 0; k < 3; k++) begin
      c[k] = gen_low + int'($urandom_range(0, gen_extent + gen_extent/8)) - gen_extent/16;
      h[k] = int'($urandom_range(0, gen_extent/8));
    end
    return make_item(op, c[0]-h[0], c[1]-h[1], c[2]-h[2], c[0]+h[0], c[1]+h[1],
                     c[2]+h[2], lst);
  endfunction

  function automatic bvhsah_pkg::item_t noise_box();
    return make_item(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, 1'($urandom_range(1)));
  endfunction

  task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '{wr: 1'b1, idx: idx, val: val, it: '0, typed: 1'b0, want: '0};
    stim_rows.insert(stim_rows.size(), r);
  endtask

  task automatic add_beat(bvhsah_pkg::item_t it, bit typed = 1'b0,
                          bvhsah_pkg::result_t want = '0);
    stim_row_t r;
    r = '{wr: 1'b0, idx: '0, val: '0, it: it, typed: typed, want: want};
    stim_rows.insert(stim_rows.size(), r);
  endtask

  // Program a normal node: random low corner, extent and area reciprocal.
  task automatic program_node(logic [1:0] ax);
    gen_low = int'($urandom_range(0, 1 << 28)) - (1 << 27);
    gen_extent = int'($urandom_range(16, 1 << 20));
    write_reg(bvhsah_pkg::REG_SPLIT_AXIS, 32'(ax));
    write_reg(bvhsah_pkg::REG_CENTROID_LOW, gen_low);
    write_reg(bvhsah_pkg::REG_INV_EXTENT, 32'((64'd1 << 32) / gen_extent));
    write_reg(bvhsah_pkg::REG_INV_NODE_AREA, $urandom_range(0, 1 << 20));
  endtask

  // Check every result beat against the oldest expectation.
  always @(posedge clk) begin
    bvhsah_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", result);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.kind !== want.kind) begin
          $error("kind: expected %h, got %h", want.kind, result.kind); err_count++;
        end
        if (result.split_found !== want.split_found) begin
          $error("split_found: expected %h, got %h", want.split_found, result.split_found);
          err_count++;
        end
        if (result.best_bucket !== want.best_bucket) begin
          $error("best_bucket: expected %0d, got %0d", want.best_bucket, result.best_bucket);
          err_count++;
        end
        if (result.best_cost !== want.best_cost) begin
          $error("best_cost: expected %h, got %h", want.best_cost, result.best_cost);
          err_count++;
        end
        if (result.count_a !== want.count_a) begin
          $error("count_a: expected %0d, got %0d", want.count_a, result.count_a);
          err_count++;
        end
        if (result.count_b !== want.count_b) begin
          $error("count_b: expected %0d, got %0d", want.count_b, result.count_b);
          err_count++;
        end
        if (result.goes_left !== want.goes_left) begin
          $error("goes_left: expected %h, got %h", want.goes_left, result.goes_left);
          err_count++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("bvh_sah_binned_split_tb: errors");
    $finish;
  end

  initial begin
    bvhsah_pkg::result_t side_left, lone_split;
    int idle_pct, beats, n;
    m_axis = bvhsah_pkg::AXIS_X; m_centroid_low = 0; m_inv_extent = 0; m_inv_area = 0;
    chosen_split = 0;
    clear_buckets();

    // Hand-checked answers: after reset every centroid maps to bucket 0.
    side_left = '0;
    side_left.kind = bvhsah_pkg::KIND_SIDE;
    side_left.goes_left = 1'b1;
    lone_split = '0;
    lone_split.kind = bvhsah_pkg::KIND_DECISION;
    lone_split.split_found = 1'b1;
    lone_split.best_cost = bvhsah_pkg::TRAVERSAL_COST;
    lone_split.count_a = 17'd1;

    // Classify before any evaluation, then a lone widest box.
    add_beat(make_item(bvhsah_pkg::OP_CLASSIFY, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, side_left);
    add_beat(make_item(bvhsah_pkg::OP_BIN, bvhsah_pkg::COORD_MIN, bvhsah_pkg::COORD_MIN,
                       bvhsah_pkg::COORD_MIN, bvhsah_pkg::COORD_MAX, bvhsah_pkg::COORD_MAX,
                       bvhsah_pkg::COORD_MAX, 1'b1), 1'b1, lone_split);
    add_beat(make_item(bvhsah_pkg::OP_CLASSIFY, bvhsah_pkg::COORD_MAX, bvhsah_pkg::COORD_MAX,
                       bvhsah_pkg::COORD_MAX, bvhsah_pkg::COORD_MAX, bvhsah_pkg::COORD_MAX,
                       bvhsah_pkg::COORD_MAX, 1'b1), 1'b1, side_left);
    // Spare axis code selects z; centroids below, inside and past the range.
    add_cfg(bvhsah_pkg::REG_SPLIT_AXIS, 32'd3);
    add_cfg(bvhsah_pkg::REG_CENTROID_LOW, 32'h0001_0000);
    add_cfg(bvhsah_pkg::REG_INV_EXTENT, 32'h0001_0000);
    add_cfg(bvhsah_pkg::REG_INV_NODE_AREA, 32'h0000_1000);
    add_beat(make_item(bvhsah_pkg::OP_BIN, 0, 0, 0, 32'h10000, 32'h10000, 0, 1'b0));
    add_beat(make_item(bvhsah_pkg::OP_BIN, 0, 0, 32'h10000, 32'h10000, 32'h10000,
                       32'h20000, 1'b0));
    add_beat(make_item(bvhsah_pkg::OP_BIN, 0, 0, 32'h50000, 32'h30000, 32'h20000,
                       32'h70000, 1'b1));
    add_beat(make_item(bvhsah_pkg::OP_CLASSIFY, 0, 0, 0, 0, 0, 0, 1'b0));
    add_beat(make_item(bvhsah_pkg::OP_CLASSIFY, 0, 0, bvhsah_pkg::COORD_MAX, 0, 0,
                       bvhsah_pkg::COORD_MAX, 1'b0));
    add_beat(make_item(bvhsah_pkg::OP_CLASSIFY, 0, 0, 32'h18000, 0, 0, 32'h18000, 1'b0));
    // Inverted box: negative extents count as zero; one side stays empty.
    add_beat(make_item(bvhsah_pkg::OP_BIN, 32'h40000, 32'h40000, 32'h40000, 0, 0, 0, 1'b1));
    add_cfg(bvhsah_pkg::REG_SPLIT_AXIS, 32'(bvhsah_pkg::AXIS_Y));
    add_beat(make_item(bvhsah_pkg::OP_BIN, bvhsah_pkg::COORD_MAX, bvhsah_pkg::COORD_MIN, 0,
                       bvhsah_pkg::COORD_MIN, bvhsah_pkg::COORD_MAX, 0, 1'b0));
    add_beat(make_item(bvhsah_pkg::OP_BIN, 0, 32'h14000, 0, 32'h8000, 32'h16000,
                       32'h8000, 1'b1));
    add_cfg(bvhsah_pkg::REG_SPLIT_AXIS, 32'(bvhsah_pkg::AXIS_X));
    add_beat(make_item(bvhsah_pkg::OP_BIN, 32'h1c000, 0, 0, 32'h1e000, 32'h1000,
                       32'h1000, 1'b0));
    add_beat(make_item(bvhsah_pkg::OP_BIN, bvhsah_pkg::COORD_MIN, bvhsah_pkg::COORD_MIN,
                       bvhsah_pkg::COORD_MIN, bvhsah_pkg::COORD_MIN, bvhsah_pkg::COORD_MIN,
                       bvhsah_pkg::COORD_MIN, 1'b1));
    add_beat(make_item(bvhsah_pkg::OP_CLASSIFY, 32'h12000, 0, 0, 32'h12000, 0, 0, 1'b0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].wr) begin
        settle();
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_beat(stim_rows[i].it, 0, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases; each one ends on a complete pass.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 0;
        default: idle_pct = 28;
      endcase
      settle();
      program_node(ph == 3 ? 2'd3 : 2'($urandom_range(0, 2)));
      case (ph)
        1: write_reg(bvhsah_pkg::REG_INV_EXTENT, 32'd0);
        2: begin
          write_reg(bvhsah_pkg::REG_INV_EXTENT, 32'hFFFF_FFFF);
          write_reg(bvhsah_pkg::REG_CENTROID_LOW, bvhsah_pkg::COORD_MAX);
        end
        3: write_reg(bvhsah_pkg::REG_CENTROID_LOW, bvhsah_pkg::COORD_MIN);
        4: write_reg(bvhsah_pkg::REG_INV_NODE_AREA, 32'd0);
        5: write_reg(bvhsah_pkg::REG_INV_NODE_AREA, 32'hFFFF_FFFF);
        default: ;
      endcase
      beats = 0;
      while (beats < 122) begin
        n = $urandom_range(99);
        if (n < 70) begin
          // Well-formed pass, then a few classifies against its split.
          n = $urandom_range(1, 16);
          for (int j = 0; j < n; j++)
            send_beat(shaped_box(bvhsah_pkg::OP_BIN, j == n - 1), idle_pct);
          repeat ($urandom_range(0, 4))
            send_beat(shaped_box(bvhsah_pkg::OP_CLASSIFY, 1'b0), idle_pct);
          beats += n + 2;
        end else if (n < 85) begin
          send_beat(shaped_box(bvhsah_pkg::OP_CLASSIFY, 1'($urandom_range(1))), idle_pct);
          beats++;
        end else begin
          send_beat(noise_box(), idle_pct);
          beats++;
        end
      end
      // Close any open pass before the next register writes.
      send_beat(shaped_box(bvhsah_pkg::OP_BIN, 1'b1), idle_pct);
    end

    settle();
    if (err_count == 0) begin
      $display("bvh_sah_binned_split_tb: clean");
    end else begin
      $display("bvh_sah_binned_split_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
design/bvhsah_pkg.sv
design/bvh_sah_binned_split.sv
tb/sv/bvh_sah_binned_split_tb.sv
